// ===== design/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpq_pkg: shared types and constants of the bounded priority queue
// Payload structs, command and state codes, and the cell interface types.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // Default number of cells
  localparam int unsigned BpqDepth = 16;

  // Field widths
  localparam int unsigned BpqPrioW = 32;
  localparam int unsigned BpqElemW = 32;
  localparam int unsigned BpqCntW  = 5;
  localparam int unsigned BpqCapW  = 5;

  // Cell index width, wide enough for the largest supported depth
  localparam int unsigned BpqIdxW  = 8;

  // Capacity after reset
  localparam logic [BpqCapW-1:0] BpqCapReset = 5'd16;

  // Configuration port
  localparam int unsigned BpqAddrW = 3;
  localparam int unsigned BpqDataW = 32;

  // Operation codes
  typedef enum logic {
    BpqCmdEnq = 1'b0,
    BpqCmdDeq = 1'b1
  } bpq_cmd_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    BpqIdle,
    BpqExec,
    BpqSearch,
    BpqCommit
  } bpq_state_e;

  // Input beat
  typedef struct packed {
    bpq_cmd_e            cmd;
    logic [BpqPrioW-1:0] priority_req;
    logic [BpqElemW-1:0] element_in;
  } bpq_req_t;

  // Result beat
  typedef struct packed {
    logic                accepted;
    logic [BpqElemW-1:0] element_out;
    logic [BpqCntW-1:0]  count;
  } bpq_rsp_t;

  // Running best entry handed from cell to cell during a search
  typedef struct packed {
    logic                valid;
    logic [BpqPrioW-1:0] prio;
    logic [BpqElemW-1:0] elem;
    logic [BpqIdxW-1:0]  idx;
  } bpq_tok_t;

  // Update command broadcast to every cell
  typedef struct packed {
    logic                max_mode;
    logic                shift_en;
    logic [BpqIdxW-1:0]  rm_idx;
    logic                app_en;
    logic [BpqIdxW-1:0]  app_idx;
    logic [BpqPrioW-1:0] app_prio;
    logic [BpqElemW-1:0] app_elem;
  } bpq_ctl_t;

endpackage

// ===== design/bpq_cell.sv =====
// ----------------------------------------------------------------------------
// bpq_cell: one storage cell of the priority queue chain
// Holds one entry, shifts down from its right neighbour on removal, takes a
// new entry on append, and passes the running best entry to the next cell.
// ----------------------------------------------------------------------------
module bpq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bpq_pkg::BpqIdxW-1:0]   idx_i,
  input  logic                          occ_i,
  input  bpq_pkg::bpq_ctl_t             ctl_i,
  input  logic [bpq_pkg::BpqPrioW-1:0]  nb_prio_i,
  input  logic [bpq_pkg::BpqElemW-1:0]  nb_elem_i,
  input  bpq_pkg::bpq_tok_t             tok_i,
  output logic [bpq_pkg::BpqPrioW-1:0]  prio_o,
  output logic [bpq_pkg::BpqElemW-1:0]  elem_o,
  output bpq_pkg::bpq_tok_t             tok_o
);

  logic [bpq_pkg::BpqPrioW-1:0] prio_q, prio_d;
  logic [bpq_pkg::BpqElemW-1:0] elem_q, elem_d;
  bpq_pkg::bpq_tok_t            tok_q, tok_d;
  logic                         better;
  logic                         take_own;

  // Compare own entry with the incoming best; strict, so the first wins ties
  assign better   = ctl_i.max_mode ? (prio_q > tok_i.prio) : (prio_q < tok_i.prio);
  assign take_own = occ_i && (!tok_i.valid || better);

  always_comb begin
    if (take_own) begin
      tok_d.valid = 1'b1;
      tok_d.prio  = prio_q;
      tok_d.elem  = elem_q;
      tok_d.idx   = idx_i;
    end else begin
      tok_d = tok_i;
    end
  end

  // Append beats shift; shift takes the right neighbour's entry
  always_comb begin
    prio_d = prio_q;
    elem_d = elem_q;
    if (ctl_i.app_en && (ctl_i.app_idx == idx_i)) begin
      prio_d = ctl_i.app_prio;
      elem_d = ctl_i.app_elem;
    end else if (ctl_i.shift_en && (idx_i >= ctl_i.rm_idx)) begin
      prio_d = nb_prio_i;
      elem_d = nb_elem_i;
    end
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    elem_q <= elem_d;
  end

  // Advance the running best
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign prio_o = prio_q;
  assign elem_o = elem_q;
  assign tok_o  = tok_q;

endmodule

// ===== design/bounded_priority_queue_evict_lowest.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_queue_evict_lowest: bounded queue with lowest eviction
// A chain of DEPTH cells in insertion order. Dequeue takes the first highest
// entry; enqueue on a full queue evicts the first lowest if the new one wins.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction  Beat
//  ------------------------------------------------------------------------
//  command   start, busy, req_i                      in         start & !busy
//  result    done_o, result_o                        out        done_o, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,   in/out     psel & penable &
//            prdata, pready                                     pwrite & pready
//
//  An enqueue into a queue below capacity, or a dequeue from an empty queue,
//  finishes in the Exec state. Any other operation goes on through Search and
//  Commit: the running best walks the cell chain one cell per cycle before
//  Commit removes or evicts an entry, if any.
//  The result appears the cycle after the operation finishes; the receiver
//  cannot stall it. Reset empties the queue and sets capacity to 16; the
//  cells need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_priority_queue_evict_lowest #(
  parameter int unsigned DEPTH = bpq_pkg::BpqDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command
  input  logic                          start,
  output logic                          busy,
  input  bpq_pkg::bpq_req_t             req_i,
  // result
  output logic                          done_o,
  output bpq_pkg::bpq_rsp_t             result_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpq_pkg::BpqAddrW-1:0]  paddr,
  input  logic [bpq_pkg::BpqDataW-1:0]  pwdata,
  output logic [bpq_pkg::BpqDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > bpq_pkg::BpqCapW) ? CntW : bpq_pkg::BpqCapW;

  bpq_pkg::bpq_state_e           state_q, state_d;
  bpq_pkg::bpq_cmd_e             cmd_q;
  logic [bpq_pkg::BpqPrioW-1:0]  prio_q;
  logic [bpq_pkg::BpqElemW-1:0]  elem_q;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [IdxW-1:0]               scan_q, scan_d;
  logic [bpq_pkg::BpqCapW-1:0]   cap_q;
  logic                          done_q, done_d;
  bpq_pkg::bpq_rsp_t             rsp_q, rsp_d;
  bpq_pkg::bpq_ctl_t             ctl;
  bpq_pkg::bpq_tok_t             best;
  logic [CmpW-1:0]               cap_w, eff_cap;
  logic                          full;
  logic                          accept;
  logic                          cfg_wr;
  logic                          scan_last;

  logic [bpq_pkg::BpqPrioW-1:0]  cell_prio [DEPTH];
  logic [bpq_pkg::BpqElemW-1:0]  cell_elem [DEPTH];
  bpq_pkg::bpq_tok_t             cell_tok  [DEPTH];

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : bpq_pkg::BpqDataW'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bpq_pkg::BpqCapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[bpq_pkg::BpqCapW-1:0];
    end
  end

  // Clamp capacity to 1..DEPTH
  assign cap_w   = CmpW'(cap_q);
  assign eff_cap = (cap_q == '0) ? CmpW'(1)
                 : ((cap_w > CmpW'(DEPTH)) ? CmpW'(DEPTH) : cap_w);
  assign full    = CmpW'(cnt_q) >= eff_cap;

  // --------------------------------------------------------------------------
  // Command capture
  // --------------------------------------------------------------------------
  assign busy   = (state_q != bpq_pkg::BpqIdle);
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.cmd;
      prio_q <= req_i.priority_req;
      elem_q <= req_i.element_in;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [bpq_pkg::BpqPrioW-1:0] nb_prio;
    logic [bpq_pkg::BpqElemW-1:0] nb_elem;
    bpq_pkg::bpq_tok_t            tok_in;

    if (g == DEPTH - 1) begin : g_tail
      assign nb_prio = cell_prio[g];
      assign nb_elem = cell_elem[g];
    end else begin : g_body
      assign nb_prio = cell_prio[g+1];
      assign nb_elem = cell_elem[g+1];
    end

    if (g == 0) begin : g_head
      assign tok_in = '0;
    end else begin : g_link
      assign tok_in = cell_tok[g-1];
    end

    bpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (bpq_pkg::BpqIdxW'(g)),
      .occ_i     (cnt_q > CntW'(g)),
      .ctl_i     (ctl),
      .nb_prio_i (nb_prio),
      .nb_elem_i (nb_elem),
      .tok_i     (tok_in),
      .prio_o    (cell_prio[g]),
      .elem_o    (cell_elem[g]),
      .tok_o     (cell_tok[g])
    );
  end

  assign best      = cell_tok[DEPTH-1];
  assign scan_last = (scan_q == IdxW'(DEPTH - 1));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpq_pkg::BpqIdle: begin
        if (accept) begin
          state_d = bpq_pkg::BpqExec;
        end
      end
      bpq_pkg::BpqExec: begin
        if ((cmd_q == bpq_pkg::BpqCmdEnq && !full) || cnt_q == '0) begin
          state_d = bpq_pkg::BpqIdle;
        end else begin
          state_d = bpq_pkg::BpqSearch;
        end
      end
      bpq_pkg::BpqSearch: begin
        if (scan_last) begin
          state_d = bpq_pkg::BpqCommit;
        end
      end
      bpq_pkg::BpqCommit: begin
        state_d = bpq_pkg::BpqIdle;
      end
      default: state_d = bpq_pkg::BpqIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: cell commands, count and result
  // --------------------------------------------------------------------------
  always_comb begin
    ctl          = '0;
    ctl.max_mode = (cmd_q == bpq_pkg::BpqCmdDeq);
    ctl.app_prio = prio_q;
    ctl.app_elem = elem_q;
    cnt_d        = cnt_q;
    scan_d       = scan_q;
    done_d       = 1'b0;
    rsp_d        = '0;
    unique case (state_q)
      bpq_pkg::BpqIdle: begin
        scan_d = '0;
      end
      bpq_pkg::BpqExec: begin
        scan_d = '0;
        // Append straight away below capacity
        if (cmd_q == bpq_pkg::BpqCmdEnq && !full) begin
          ctl.app_en     = 1'b1;
          ctl.app_idx    = bpq_pkg::BpqIdxW'(cnt_q);
          cnt_d          = cnt_q + CntW'(1);
          done_d         = 1'b1;
          rsp_d.accepted = 1'b1;
          rsp_d.count    = bpq_pkg::BpqCntW'(cnt_d);
        end else if (cnt_q == '0) begin
          // Dequeue from an empty queue fails
          done_d = 1'b1;
        end
      end
      bpq_pkg::BpqSearch: begin
        scan_d = scan_q + IdxW'(1);
      end
      bpq_pkg::BpqCommit: begin
        done_d = 1'b1;
        if (cmd_q == bpq_pkg::BpqCmdDeq) begin
          // Remove the first highest entry and return it
          ctl.shift_en      = 1'b1;
          ctl.rm_idx        = best.idx;
          cnt_d             = cnt_q - CntW'(1);
          rsp_d.accepted    = 1'b1;
          rsp_d.element_out = best.elem;
        end else if (best.prio < prio_q) begin
          // Evict the first lowest entry and append the new one at the end
          ctl.shift_en   = 1'b1;
          ctl.rm_idx     = best.idx;
          ctl.app_en     = 1'b1;
          ctl.app_idx    = bpq_pkg::BpqIdxW'(cnt_q - CntW'(1));
          rsp_d.accepted = 1'b1;
        end
        rsp_d.count = bpq_pkg::BpqCntW'(cnt_d);
      end
      default: begin
        scan_d = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpq_pkg::BpqIdle;
      cnt_q   <= '0;
      scan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      done_q  <= done_d;
    end
  end

  // Hold the result beat
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == bpq_pkg::BpqExec || $past(state_q) == bpq_pkg::BpqCommit))
    else $error("result beat without a finishing state");

  a_search_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpq_pkg::BpqSearch && scan_last) |=> state_q == bpq_pkg::BpqCommit)
    else $error("search did not end in commit");

  a_evict_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpq_pkg::BpqCommit && cmd_q == bpq_pkg::BpqCmdEnq) |=> $stable(cnt_q))
    else $error("eviction changed the entry count");

  a_best_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpq_pkg::BpqCommit |-> best.valid)
    else $error("commit without a search result");

endmodule
